/* rtl/azrle_pkg.sv */
// Types and constants for the ADC zero run-length encoder.
// Used by azrle_encoder, azrle_queue and adc_zero_run_length_encoder.
package azrle_pkg;

    localparam logic [14:0] MINUS_CAP = 15'd16000;
    localparam logic [15:0] ZERO_BASE = 16'd16001;
    localparam logic [14:0] ZERO_CAP  = 15'd16766;

    // Output queue size; the pointers wrap naturally, so it must stay a power of two.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_MINUS = 2'd1,
        RUN_ZERO  = 2'd2
    } run_kind_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_last;
    } sample_item_t;

    typedef struct packed {
        logic signed [15:0] code;
        logic               end_of_array;
    } code_item_t;

    // Up to two code words produced by one sample, in output order.
    typedef struct packed {
        logic [1:0] count;
        code_item_t first;
        code_item_t second;
    } enc_push_t;

endpackage

/* rtl/azrle_encoder.sv */
// Run tracking and code word generation for one accepted sample.
// Depends on azrle_pkg.
module azrle_encoder
    import azrle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  sample_item_t item,
    output enc_push_t    push
);

    run_kind_t   run_kind_reg;
    run_kind_t   run_kind_next;
    logic [14:0] run_length_reg;
    logic [14:0] run_length_next;

    run_kind_t   kind;
    logic        flush_old;
    logic        emit_new;
    logic [14:0] new_length;
    logic [14:0] cap;
    logic [15:0] old_mag;
    logic [15:0] new_mag;
    code_item_t  old_word;
    code_item_t  new_word;
    logic        new_valid;

    always_comb
    begin
        if (item.sample == -16'sd1)
        begin
            kind = RUN_MINUS;
        end
        else if (item.sample == 16'sd0)
        begin
            kind = RUN_ZERO;
        end
        else
        begin
            kind = RUN_NONE;
        end

        flush_old = (run_kind_reg != RUN_NONE) && (run_kind_reg != kind);

        if (run_kind_reg == RUN_MINUS)
        begin
            old_mag = {1'b0, run_length_reg};
        end
        else
        begin
            old_mag = ZERO_BASE + {1'b0, run_length_reg};
        end
        old_word.code         = -$signed(old_mag);
        old_word.end_of_array = 1'b0;

        if (run_kind_reg == kind)
        begin
            new_length = run_length_reg + 15'd1;
        end
        else
        begin
            new_length = 15'd1;
        end

        cap = (kind == RUN_MINUS) ? MINUS_CAP : ZERO_CAP;

        if (kind == RUN_MINUS)
        begin
            new_mag = {1'b0, new_length};
        end
        else
        begin
            new_mag = ZERO_BASE + {1'b0, new_length};
        end

        emit_new = (new_length >= cap) || item.is_last;

        // A value sample always produces itself; a run sample only when its run closes.
        case (kind)
            RUN_MINUS, RUN_ZERO:
            begin
                new_valid     = emit_new;
                new_word.code = -$signed(new_mag);
            end
            default:
            begin
                new_valid     = 1'b1;
                new_word.code = item.sample;
            end
        endcase
        new_word.end_of_array = item.is_last;

        if (kind == RUN_NONE || emit_new)
        begin
            run_kind_next   = RUN_NONE;
            run_length_next = 15'd0;
        end
        else
        begin
            run_kind_next   = kind;
            run_length_next = new_length;
        end

        push.count  = {1'b0, flush_old} + {1'b0, new_valid};
        push.second = new_word;
        if (flush_old)
        begin
            push.first = old_word;
            // The flushed run is the final word only when nothing follows it.
            push.first.end_of_array = item.is_last && !new_valid;
        end
        else
        begin
            push.first = new_word;
        end

        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg   <= RUN_NONE;
            run_length_reg <= 15'd0;
        end
        else if (accept)
        begin
            run_kind_reg   <= run_kind_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

/* rtl/azrle_queue.sv */
// Small output queue taking up to two code words per cycle and giving one
// when code_stall is low. Depends on azrle_pkg.
module azrle_queue
    import azrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  enc_push_t  push,
    output logic       room,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_item
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    code_item_t     entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [PW:0]    count_reg;
    logic [PW:0]    count_next;
    logic           pop;
    logic [PW-1:0]  wr_ptr_second;

    assign code_valid    = count_reg != '0;
    assign code_item     = entry_reg[rd_ptr_reg];
    assign pop           = code_valid && !code_stall;
    assign room          = count_reg <= (PW+1)'(DEPTH - 2);
    assign wr_ptr_second = wr_ptr_reg + PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push.count) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push.count != 2'd0 && PW'(i) == wr_ptr_reg)
            begin
                entry_reg[i] <= push.first;
            end
            else if (push.count == 2'd2 && PW'(i) == wr_ptr_second)
            begin
                entry_reg[i] <= push.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/adc_zero_run_length_encoder.sv */
// Top level of the ADC zero run-length encoder.
// Depends on azrle_pkg, azrle_encoder and azrle_queue.
//
// Usage:
//   Samples enter on the sample channel (sample_valid, sample_stall, sample_item)
//   and code words leave on the code channel (code_valid, code_stall, code_item).
//   An item moves when valid is high and stall is low at a rising clock edge.
//   Samples other than -1 and 0 pass through; runs of -1 or 0 are packed into
//   negative code words, one per run up to its cap, and end_of_array marks the last word of an array.
//
// Queueing and throughput:
//   A sample's words enter the output queue at the edge that accepts it.
//   One sample is accepted every cycle while the queue has room. A sample that
//   closes a run and also yields a word of its own produces two words; the
//   single output port then sets the rate, since the code channel drains one
//   word per cycle unless stalled. sample_stall rises while the queue lacks
//   room for two words.
//
// Reset and stalls:
//   rst_n clears the open run and empties the queue. While the receiver stalls,
//   words wait in the queue and the head word is held steady on code_item.
module adc_zero_run_length_encoder
    import azrle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    output logic         code_valid,
    input  logic         code_stall,
    output code_item_t   code_item
);

    logic      accept;
    logic      room;
    enc_push_t push;

    assign sample_stall = !room;
    assign accept       = sample_valid && room;

    azrle_encoder u_encoder
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (sample_item),
        .push   (push)
    );

    azrle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item)
    );

endmodule

/* tb/sv/adc_zero_run_length_encoder_tb.sv */
// Self-checking testbench for adc_zero_run_length_encoder: a directed table,
// then random runs and values with random idling and one long output hold-off.
// Depends on azrle_pkg and the encoder RTL.
module adc_zero_run_length_encoder_tb
    import azrle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_TYPED      = -1;
    localparam int NUM_DIRECTED  = 24;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CALM_TAIL     = 150;
    localparam int LONG_HOLD     = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         sample_valid = 1'b0;
    logic         sample_stall;
    sample_item_t sample_item = '0;
    logic         code_valid;
    logic         code_stall = 1'b0;
    code_item_t   code_item;

    // One row of directed stimulus. Where n is NO_TYPED the expected words
    // come from the encoder model; otherwise n words are given here.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        int                 reps;
        int                 n;
        logic signed [15:0] c0;
        logic               e0;
        logic signed [15:0] c1;
        logic               e1;
    } dir_row_t;

    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'sd32767,  1'b0, 1,     1,        16'sd32767,  1'b0, 16'sd0,     1'b0},
        '{16'sd1,      1'b0, 1,     1,        16'sd1,      1'b0, 16'sd0,     1'b0},
        '{-16'sd1,     1'b1, 1,     1,        -16'sd1,     1'b1, 16'sd0,     1'b0},
        '{16'sd0,      1'b1, 1,     1,        -16'sd16002, 1'b1, 16'sd0,     1'b0},
        '{16'sd0,      1'b0, 3,     NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{-16'sd1,     1'b0, 1,     1,        -16'sd16004, 1'b0, 16'sd0,     1'b0},
        '{-16'sd1,     1'b0, 2,     NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{16'sd5,      1'b0, 1,     2,        -16'sd3,     1'b0, 16'sd5,     1'b0},
        '{-16'sd32768, 1'b0, 1,     1,        -16'sd32768, 1'b0, 16'sd0,     1'b0},
        '{16'sd0,      1'b0, 1,     0,        16'sd0,      1'b0, 16'sd0,     1'b0},
        '{-16'sd2,     1'b0, 1,     2,        -16'sd16002, 1'b0, -16'sd2,    1'b0},
        '{16'sd21845,  1'b0, 1,     1,        16'sd21845,  1'b0, 16'sd0,     1'b0},
        '{16'sd10922,  1'b1, 1,     1,        16'sd10922,  1'b1, 16'sd0,     1'b0},
        '{-16'sd1,     1'b0, 16000, NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{-16'sd1,     1'b0, 1,     0,        16'sd0,      1'b0, 16'sd0,     1'b0},
        '{16'sd0,      1'b0, 16766, NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{16'sd0,      1'b1, 1,     1,        -16'sd16002, 1'b1, 16'sd0,     1'b0},
        '{-16'sd1,     1'b0, 15999, NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{-16'sd1,     1'b1, 1,     1,        -16'sd16000, 1'b1, 16'sd0,     1'b0},
        '{16'sd0,      1'b0, 4,     NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{16'sd123,    1'b1, 1,     2,        -16'sd16005, 1'b0, 16'sd123,   1'b1},
        '{-16'sd1,     1'b0, 2,     NO_TYPED, 16'sd0,      1'b0, 16'sd0,     1'b0},
        '{16'sd0,      1'b1, 1,     2,        -16'sd2,     1'b0, -16'sd16002, 1'b1},
        '{16'sd16384,  1'b1, 1,     1,        16'sd16384,  1'b1, 16'sd0,     1'b0}
    };

    // Encoder model state: the kind and length of the run still open.
    run_kind_t   open_kind = RUN_NONE;
    logic [14:0] open_len = '0;

    code_item_t pending_codes [$];
    code_item_t oldest_code;
    int         errors = 0;
    int         quiet_cycles = 0;
    bit         idling_on = 1'b1;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;

    adc_zero_run_length_encoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code_item    (code_item)
    );

    always #5 clk = ~clk;

    // Packs the open run into its negative code word and closes it.
    function automatic code_item_t close_run();
        code_item_t  word;
        logic [15:0] mag;
        mag = (open_kind == RUN_MINUS) ? {1'b0, open_len} : ZERO_BASE + {1'b0, open_len};
        word.code = 16'd0 - mag;
        word.end_of_array = 1'b0;
        open_kind = RUN_NONE;
        open_len = '0;
        return word;
    endfunction

    function automatic int encode_sample(input sample_item_t it,
                                         output code_item_t [1:0] words);
        run_kind_t   kind;
        logic [14:0] cap;
        int          n;
        n = 0;
        words = '0;
        if (it.sample == -16'sd1)
            kind = RUN_MINUS;
        else if (it.sample == 16'sd0)
            kind = RUN_ZERO;
        else
            kind = RUN_NONE;
        if (open_kind != RUN_NONE && open_kind != kind)
        begin
            words[n] = close_run();
            n++;
        end
        if (kind == RUN_NONE)
        begin
            words[n].code = it.sample;
            words[n].end_of_array = 1'b0;
            n++;
        end
        else
        begin
            if (open_kind == kind)
                open_len = open_len + 15'd1;
            else
            begin
                open_kind = kind;
                open_len = 15'd1;
            end
            cap = (kind == RUN_MINUS) ? MINUS_CAP : ZERO_CAP;
            if (open_len >= cap || it.is_last)
            begin
                words[n] = close_run();
                n++;
            end
        end
        if (it.is_last)
        begin
            open_kind = RUN_NONE;
            open_len = '0;
            if (n > 0)
                words[n - 1].end_of_array = 1'b1;
        end
        return n;
    endfunction

    // Offers one sample, waits for it to be taken, queues its code words and
    // sometimes leaves a gap afterwards.
    task automatic offer_sample(input sample_item_t it, input int typed_n,
                                input code_item_t [1:0] typed_words);
        code_item_t [1:0] words;
        int               n;
        sample_item <= it;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        n = encode_sample(it, words);
        if (typed_n != NO_TYPED)
        begin
            n = typed_n;
            words = typed_words;
        end
        for (int i = 0; i < n; i++)
            pending_codes.push_back(words[i]);
        if (idling_on && !(hold_req && !hold_done) && $urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic offer_random(input logic signed [15:0] value);
        sample_item_t it;
        it.sample = value;
        it.is_last = ($urandom_range(0, 19) == 0);
        offer_sample(it, NO_TYPED, '0);
    endtask

    task automatic run_directed();
        sample_item_t     it;
        code_item_t [1:0] typed_words;
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            it.sample = directed_rows[r].sample;
            it.is_last = directed_rows[r].last;
            typed_words[0] = {directed_rows[r].c0, directed_rows[r].e0};
            typed_words[1] = {directed_rows[r].c1, directed_rows[r].e1};
            for (int k = 0; k < directed_rows[r].reps; k++)
                offer_sample(it, directed_rows[r].n, typed_words);
        end
    endtask

    task automatic run_random();
        int                 sent;
        int                 next_switch;
        int                 pick;
        int                 len;
        logic signed [15:0] value;
        sent = 0;
        next_switch = 0;
        hold_req = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_switch)
            begin
                idling_on = ($urandom_range(0, 3) != 0);
                next_switch = sent + 100;
            end
            if (sent >= RANDOM_ITEMS - CALM_TAIL)
                idling_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if (pick < 3)
                    value = 16'sd32767;
                else if (pick < 5)
                    value = 16'sd1;
                else
                    value = 16'($urandom_range(1, 32767));
                offer_random(value);
                sent++;
            end
            else if (pick < 96)
            begin
                // Short runs only; the runs that reach their caps are in the table.
                value = (pick < 68) ? -16'sd1 : 16'sd0;
                len = $urandom_range(1, 12);
                sent += len;
                for (int j = 0; j < len; j++)
                    offer_random(value);
            end
            else
            begin
                // Samples below -1 lie outside the stated range and pass through.
                value = 16'(-$urandom_range(2, 32768));
                offer_random(value);
                sent++;
            end
        end
    endtask

    // Output side: random stall bursts and one long hold-off that backs the
    // queue up until the encoder stalls its input.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                code_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                code_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (idling_on && $urandom_range(0, 15) == 0)
            begin
                code_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                code_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && code_valid && !code_stall)
        begin
            if (pending_codes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected code word %0d end_of_array %0b", $time,
                             code_item.code, code_item.end_of_array);
            end
            else
            begin
                oldest_code = pending_codes.pop_front();
                if (code_item.code !== oldest_code.code)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: code mismatch: expected %0d, got %0d", $time,
                                 oldest_code.code, code_item.code);
                end
                if (code_item.end_of_array !== oldest_code.end_of_array)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: end_of_array mismatch: expected %0b, got %0b",
                                 $time, oldest_code.end_of_array, code_item.end_of_array);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (code_valid && !code_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        sample_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0 && pending_codes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* adc_zero_run_length_encoder.f */
rtl/azrle_pkg.sv
rtl/azrle_encoder.sv
rtl/azrle_queue.sv
rtl/adc_zero_run_length_encoder.sv
tb/sv/adc_zero_run_length_encoder_tb.sv
